// ----- rtl/core/encoder_speed_estimator_macros.svh -----
// ----------------------------------------------------------------------------
// Encoder speed estimator assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_ESTIMATOR_MACROS_SVH
`define ENCODER_SPEED_ESTIMATOR_MACROS_SVH

// Same-cycle implication.
`define ES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("encoder_speed_estimator: check failed");

// Next-cycle implication.
`define ES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("encoder_speed_estimator: check failed");

`endif

// ----- rtl/core/es_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Widths, constants, item kinds, state codes and controller interface types.
// ----------------------------------------------------------------------------
package es_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned SpeedW = 27;
  localparam int unsigned MagW   = CountW + 1;  // |delta| reaches 2^15
  localparam int unsigned TnumW  = 29;          // 32768 * 10000 < 2^29
  localparam int unsigned SquoW  = 26;          // 40000000 < 2^26
  localparam int unsigned OutW   = 88;          // 86 payload bits, byte padded

  localparam logic [TimeW-1:0]  SpeedNum    = 32'd40000000;
  localparam logic [13:0]       TickScale   = 14'd10000;
  localparam logic [CountW-1:0] LoopTimeRst = 16'd20;

  typedef enum logic [1:0] {
    KindLeft  = 2'd0,
    KindRight = 2'd1,
    KindRead  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StStartS,
    StWaitS,
    StStartT,
    StWaitT,
    StFinish
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic start_s;   // launch 40e6 / period
    logic save_s;    // keep period quotient
    logic start_t;   // launch |delta|*10000 / loop time
    logic load_out;  // form result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/es_div.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator divider
// Restoring 32/32 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module es_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [es_pkg::TimeW-1:0] dividend_i,
  input  logic [es_pkg::TimeW-1:0] divisor_i,
  output logic                     done_o,
  output logic [es_pkg::TimeW-1:0] quotient_o
);
  import es_pkg::*;

  localparam int unsigned CntW = $clog2(TimeW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0] rem_q, rem_d;
  logic [TimeW-1:0] quo_q, quo_d;
  logic [TimeW-1:0] dsr_q, dsr_d;
  logic [TimeW:0]   shifted;
  logic [TimeW+1:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[TimeW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(TimeW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[TimeW+1]) begin
        rem_d = diff[TimeW-1:0];
        quo_d = {quo_q[TimeW-2:0], 1'b1};
      end else begin
        rem_d = shifted[TimeW-1:0];
        quo_d = {quo_q[TimeW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/es_datapath.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator datapath
// Edge period capture, count deltas, two divider lanes and the result register.
// ----------------------------------------------------------------------------
module es_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  es_pkg::cmd_t              cmd_i,
  output es_pkg::stat_t             stat_o,
  input  logic                      cfg_we_i,
  input  logic [es_pkg::CountW-1:0] cfg_data_i,
  input  logic [1:0]                in_kind_i,
  input  logic [es_pkg::TimeW-1:0]  in_time_i,
  input  logic [es_pkg::CountW-1:0] in_count_l_i,
  input  logic [es_pkg::CountW-1:0] in_count_r_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [es_pkg::OutW-1:0]   out_data_o
);
  import es_pkg::*;

  // side 0 is left, side 1 is right
  logic [CountW-1:0]           loop_time_q;
  logic [1:0][TimeW-1:0]       last_q;
  logic [1:0][TimeW-1:0]       per_q;
  logic [1:0][CountW-1:0]      prev_q;
  logic [1:0][CountW-1:0]      cnt_in;
  logic [1:0][CountW-1:0]      delta_c;
  logic [1:0][MagW-1:0]        mag_c;

  logic [1:0][TimeW-1:0]       wper_q;
  logic [1:0]                  pos_q;
  logic [1:0][CountW-1:0]      delta_q;
  logic [1:0][MagW-1:0]        mag_q;
  logic [1:0][TnumW-1:0]       tnum_q;
  logic [1:0][SquoW-1:0]       squo_q;

  logic [TimeW-1:0]            lt_eff;
  logic [1:0]                  div_done;
  logic [1:0][TimeW-1:0]       quo;
  logic [1:0][TimeW-1:0]       dvd;
  logic [1:0][TimeW-1:0]       dvs;
  logic [1:0][SpeedW-1:0]      speed_c;

  logic                        out_valid_q;
  logic [1:0][CountW-1:0]      out_delta_q;
  logic [1:0][SpeedW-1:0]      out_speed_q;

  logic [TimeW-1:0]            s32;
  logic [TimeW-1:0]            t32;
  logic                        clamp;
  logic [TnumW-1:0]            pick;
  logic [TnumW-1:0]            sgn;

  assign cnt_in[0] = in_count_l_i;
  assign cnt_in[1] = in_count_r_i;
  assign lt_eff    = (loop_time_q == '0) ? TimeW'(1) : {{(TimeW-CountW){1'b0}}, loop_time_q};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      delta_c[i] = cnt_in[i] - prev_q[i];
      mag_c[i]   = delta_c[i][CountW-1] ? (MagW'(17'h10000) - {1'b0, delta_c[i]})
                                        : {1'b0, delta_c[i]};
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_time_q <= LoopTimeRst;
      last_q      <= '0;
      per_q       <= '0;
      prev_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        loop_time_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        case (in_kind_i)
          KindLeft: begin
            per_q[0]  <= in_time_i - last_q[0];
            last_q[0] <= in_time_i;
          end
          KindRight: begin
            per_q[1]  <= in_time_i - last_q[1];
            last_q[1] <= in_time_i;
          end
          KindRead: begin
            per_q     <= '0;
            prev_q[0] <= in_count_l_i;
            prev_q[1] <= in_count_r_i;
          end
          default: ;
        endcase
      end
    end
  end

  // working registers of a read item
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.take && (in_kind_i == KindRead)) begin
        wper_q[i]  <= per_q[i];
        pos_q[i]   <= (per_q[i] != '0) && !per_q[i][TimeW-1];
        delta_q[i] <= delta_c[i];
        mag_q[i]   <= mag_c[i];
      end
      if (cmd_i.start_s) begin
        tnum_q[i] <= TnumW'({{(TnumW-MagW){1'b0}}, mag_q[i]}
                          * {{(TnumW-14){1'b0}}, TickScale});
      end
      if (cmd_i.save_s) begin
        squo_q[i] <= quo[i][SquoW-1:0];
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    assign dvd[g] = cmd_i.start_t ? {{(TimeW-TnumW){1'b0}}, tnum_q[g]} : SpeedNum;
    assign dvs[g] = cmd_i.start_t ? lt_eff : wper_q[g];

    es_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.start_s | cmd_i.start_t),
      .dividend_i (dvd[g]),
      .divisor_i  (dvs[g]),
      .done_o     (div_done[g]),
      .quotient_o (quo[g])
    );
  end

  // clamp to the count-based speed when 2*S > 3*T, then apply the sign; zero when the period is not positive
  always_comb begin
    s32   = '0;
    t32   = '0;
    clamp = 1'b0;
    pick  = '0;
    sgn   = '0;
    for (int i = 0; i < 2; i++) begin
      s32   = {{(TimeW-SquoW){1'b0}}, squo_q[i]};
      t32   = {{(TimeW-TnumW){1'b0}}, quo[i][TnumW-1:0]};
      clamp = {s32[TimeW-2:0], 1'b0} > (t32 + {t32[TimeW-2:0], 1'b0});
      pick  = clamp ? quo[i][TnumW-1:0] : {{(TnumW-SquoW){1'b0}}, squo_q[i]};
      sgn   = delta_q[i][CountW-1] ? (TnumW'(0) - pick) : pick;
      speed_c[i] = pos_q[i] ? sgn[SpeedW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_delta_q <= delta_q;
      out_speed_q <= speed_c;
    end
  end

  assign stat_o.div_done = div_done[0] & div_done[1];
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, out_speed_q[1], out_speed_q[0], out_delta_q[1], out_delta_q[0]};

endmodule

// ----- rtl/core/es_ctrl.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator controller
// Sequences a read item through the two division rounds into the output.
// ----------------------------------------------------------------------------
module es_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_kind_i,
  output logic          in_ready_o,
  input  es_pkg::stat_t stat_i,
  output es_pkg::cmd_t  cmd_o
);
  import es_pkg::*;

  state_e state_q, state_d;
  logic   is_read;

  assign is_read = (in_kind_i == KindRead);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i && is_read) state_d = StStartS;
      StStartS: state_d = StWaitS;
      StWaitS:  if (stat_i.div_done) state_d = StStartT;
      StStartT: state_d = StWaitT;
      StWaitT:  if (stat_i.div_done) state_d = StFinish;
      StFinish: if (stat_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      StStartS: cmd_o.start_s  = 1'b1;
      StWaitS:  cmd_o.save_s   = stat_i.div_done;
      StStartT: cmd_o.start_t  = 1'b1;
      StWaitT:  ;
      StFinish: cmd_o.load_out = stat_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/encoder_speed_estimator.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator
// Two-wheel speed from edge periods, limited by the count-based speed.
// ----------------------------------------------------------------------------
// Edge items (tuser kind left or right) record the period since that wheel's
// previous rising edge and do not hold up the block; they give no result.
// A read item (kind read) latches both counter values and the two periods,
// clears the periods and produces one result, computed by
// two serial dividers, one per wheel, each run twice at one quotient bit per
// cycle (40e6 / period, then |delta| * 10000 / loop time), plus the setup and
// finish steps. No item is taken while a read is in progress. The result sits
// in an output register, so the block returns to accepting items as soon as
// the result is loaded; a read that finishes while the previous result is
// still unclaimed waits in its last step. Kind 3 items are taken and ignored.
// The loop time register resets to 20 ms; zero is treated as 1 ms. Write it
// only while the block is idle; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module encoder_speed_estimator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: loop time in ms
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [es_pkg::CountW-1:0] cfg_data_i,
  // input items
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // timestamp_us, count_left, count_right
  input  logic [1:0]                s_axis_tuser,  // kind
  // result items
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [es_pkg::OutW-1:0]   m_axis_tdata   // delta_left, delta_right,
                                                   // speed_left, speed_right, pad
);
  import es_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  es_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  es_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_kind_i    (s_axis_tuser),
    .in_time_i    (s_axis_tdata[31:0]),
    .in_count_l_i (s_axis_tdata[47:32]),
    .in_count_r_i (s_axis_tdata[63:48]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule

// ----- rtl/core/es_checker.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator checker
// Port-level checks on item sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "encoder_speed_estimator_macros.svh"

module es_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic [1:0]              s_axis_tuser,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [es_pkg::OutW-1:0] m_axis_tdata
);
  import es_pkg::*;

  logic in_take;
  logic out_stall;

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result stays put
  `ES_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // a read item occupies the block and cannot yield a result at once
  `ES_ASSERT_NXT(a_read_busy, in_take && s_axis_tuser == KindRead, !s_axis_tready && !$rose(m_axis_tvalid))

  // edge items leave the block ready again in the next cycle
  `ES_ASSERT_NXT(a_edge_quick, in_take && s_axis_tuser != KindRead, s_axis_tready)

  // a new result appears together with the return to idle
  `ES_ASSERT_IMP(a_result_idle, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind encoder_speed_estimator es_checker u_es_checker (.*);
